// File: hw/rtl/shs_pkg.sv
`timescale 1ns / 1ps

package shs_pkg;

	localparam int WordW     = 32;
	localparam int BlkDepth  = 16;
	localparam int HashDepth = 8;
	localparam int BlkAw     = 4;
	localparam int HashAw    = 3;
	localparam int PosW      = 6;
	localparam int LenW      = 64;
	localparam int CntW      = 7;

	localparam logic [7:0]      PadByte    = 8'h80;
	localparam logic [7:0]      ZeroByte   = 8'h00;
	localparam logic [PosW-1:0] LenPos     = 6'd56;
	localparam logic [PosW-1:0] PosLast    = 6'd63;
	localparam logic [LenW-1:0] BitsByte   = 64'd8;
	localparam logic [CntW-1:0] LoadLast   = 7'd16;
	localparam logic [CntW-1:0] HashLdLast = 7'd8;
	localparam logic [CntW-1:0] RoundLast  = 7'd63;
	localparam logic [CntW-1:0] FinLast    = 7'd8;
	localparam logic [1:0]      PartLast   = 2'd3;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_RD_HI,
		ST_RD_LO,
		ST_RD_CAP
	} top_state_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_LOAD,
		C_ROUND,
		C_FIN
	} core_state_t;

	typedef struct packed {
		logic start;
		logic rehash;
	} core_ctl_t;

	function automatic word_t init_hash(input logic [HashAw-1:0] idx);
		word_t r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = 32'h6a09e667;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] t);
		word_t r;
		case (t)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
			default: r = 32'h428a2f98;
		endcase
		return r;
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// File: hw/rtl/shs_if.sv
`timescale 1ns / 1ps

interface shs_byte_if import shs_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       last_of_message;

	modport source (output valid, data_byte, byte_present, last_of_message, input ready);
	modport sink   (input valid, data_byte, byte_present, last_of_message, output ready);
endinterface

interface shs_digest_if import shs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [2*WordW-1:0]    digest_part;
	logic [1:0]            part_index;
	logic                  last_part;

	modport source (output valid, digest_part, part_index, last_part, input ready);
	modport sink   (input valid, digest_part, part_index, last_part, output ready);
endinterface

// File: hw/rtl/shs_blk_mem.sv
`timescale 1ns / 1ps

module shs_blk_mem import shs_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [BlkAw-1:0] waddr,
	input  word_t            wdata,
	input  logic [BlkAw-1:0] raddr,
	output word_t            rdata
);

	word_t mem [BlkDepth];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/shs_core.sv
`timescale 1ns / 1ps

module shs_core import shs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  core_ctl_t         ctl,
	output logic              done,
	output logic [BlkAw-1:0]  blk_addr,
	input  word_t             blk_data,
	input  logic [HashAw-1:0] rd_addr,
	output word_t             rd_data
);

	core_state_t state_q, state_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic fresh_q;

	word_t hash_mem [HashDepth];
	word_t hash_rd_q;
	logic [HashAw-1:0] hash_raddr;
	logic [HashAw-1:0] hash_waddr;
	logic hash_we;
	word_t hash_wdata;
	word_t base;

	word_t w_q [BlkDepth];
	word_t v_q [HashDepth];
	logic w_load;
	logic v_load;

	word_t t1, t2, w_next;

	always_comb begin
		hash_waddr = cnt_q[HashAw-1:0] - 3'd1;
		base = fresh_q ? init_hash(hash_waddr) : hash_rd_q;
		hash_wdata = base + v_q[0];

		t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_k(cnt_q[5:0]) + w_q[0];
		t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_next = w_q[0] + small_sigma0(w_q[1]) + w_q[9] + small_sigma1(w_q[14]);
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		blk_addr = cnt_q[BlkAw-1:0];
		hash_raddr = (state_q == C_IDLE) ? rd_addr : cnt_q[HashAw-1:0];
		hash_we = 1'b0;
		w_load = 1'b0;
		v_load = 1'b0;
		done = 1'b0;
		case (state_q)
			C_IDLE: begin
				if (ctl.start) begin
					state_d = C_LOAD;
					cnt_d = '0;
				end
			end
			C_LOAD: begin
				w_load = (cnt_q != '0);
				v_load = (cnt_q != '0) && (cnt_q <= HashLdLast);
				if (cnt_q == LoadLast) begin
					state_d = C_ROUND;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			C_ROUND: begin
				if (cnt_q == RoundLast) begin
					state_d = C_FIN;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			C_FIN: begin
				hash_we = (cnt_q != '0);
				if (cnt_q == FinLast) begin
					state_d = C_IDLE;
					cnt_d = '0;
					done = 1'b1;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q <= '0;
			fresh_q <= 1'b1;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (ctl.rehash) begin
				fresh_q <= 1'b1;
			end else if (done) begin
				fresh_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hash_we) begin
			hash_mem[hash_waddr] <= hash_wdata;
		end
		hash_rd_q <= hash_mem[hash_raddr];
	end

	// message schedule window, w_q[0] is the word of the current round
	always_ff @(posedge clk) begin
		if (w_load || state_q == C_ROUND) begin
			for (int i = 0; i < BlkDepth - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BlkDepth-1] <= w_load ? blk_data : w_next;
		end
	end

	always_ff @(posedge clk) begin
		if (v_load || hash_we) begin
			for (int i = 0; i < HashDepth - 1; i++) begin
				v_q[i] <= v_q[i+1];
			end
			v_q[HashDepth-1] <= v_load ? base : v_q[0];
		end else if (state_q == C_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign rd_data = hash_rd_q;

endmodule

// File: hw/rtl/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps

// channel   dir  fields                                         role
// msg       in   data_byte[8] byte_present last_of_message      at most one message byte per item
// digest    out  digest_part[64] part_index[2] last_part        four digest quarters
//
// byte items are accepted back to back while idle; the item filling a block adds a compression
// (block and hash memory reads, 64 rounds, hash memory updates)
// a final item adds a pad byte per pad position, one or two compressions and
// hash memory reads for each digest part
// reset clears all control state; hash memory is marked initial, no clearing pass
// msg stalls while padding, compressing or reading out; part 3 may wait in the
// output register while the next message streams in

module sha256_stream_hasher_top import shs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	shs_byte_if.sink    msg,
	shs_digest_if.source digest
);

	top_state_t state_q, state_d, after_q, after_d;
	logic [PosW-1:0] pos_q;
	logic [LenW-1:0] len_q, len_d;
	word_t word_q;
	logic first_q, first_d;
	logic tail_q, tail_d;
	logic [1:0] part_q, part_d;
	word_t hi_q, hi_d;

	logic out_valid_q;
	logic [2*WordW-1:0] out_data_q;
	logic [1:0] out_idx_q;
	logic out_last_q;
	logic out_load;

	logic accept;
	logic put_en;
	logic [7:0] put_val;
	logic [7:0] len_byte;
	logic [PosW-1:0] len_sh;
	logic tail_eff;
	word_t put_word;

	core_ctl_t ctl;
	logic core_done;
	logic [BlkAw-1:0] blk_raddr;
	word_t blk_rdata;
	logic [HashAw-1:0] hash_addr;
	word_t hash_data;

	assign msg.ready = (state_q == ST_IDLE);
	assign accept = msg.valid && msg.ready;
	assign len_sh = {~pos_q[2:0], 3'b000};
	assign len_byte = 8'(len_q >> len_sh);
	assign put_word = {word_q[WordW-9:0], put_val};

	always_comb begin
		state_d = state_q;
		after_d = after_q;
		len_d = len_q;
		first_d = first_q;
		tail_d = tail_q;
		part_d = part_q;
		hi_d = hi_q;
		put_en = 1'b0;
		put_val = msg.data_byte;
		tail_eff = tail_q;
		out_load = 1'b0;
		ctl = '0;
		hash_addr = {part_q, 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (msg.byte_present) begin
						put_en = 1'b1;
						len_d = len_q + BitsByte;
					end
					if (msg.last_of_message) begin
						first_d = 1'b1;
					end
					if (msg.byte_present && pos_q == PosLast) begin
						ctl.start = 1'b1;
						state_d = ST_COMP;
						after_d = msg.last_of_message ? ST_PAD : ST_IDLE;
					end else if (msg.last_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				put_en = 1'b1;
				first_d = 1'b0;
				if (first_q) begin
					put_val = PadByte;
					tail_eff = (pos_q >= LenPos);
					tail_d = tail_eff;
				end else if (pos_q >= LenPos && !tail_q) begin
					put_val = len_byte;
				end else begin
					put_val = ZeroByte;
				end
				if (pos_q == PosLast) begin
					ctl.start = 1'b1;
					state_d = ST_COMP;
					tail_d = 1'b0;
					if (tail_eff) begin
						after_d = ST_PAD;
					end else begin
						after_d = ST_RD_HI;
						len_d = '0;
					end
				end
			end
			ST_COMP: begin
				if (core_done) begin
					state_d = after_q;
				end
			end
			ST_RD_HI: begin
				if (!out_valid_q || digest.ready) begin
					state_d = ST_RD_LO;
				end
			end
			ST_RD_LO: begin
				hash_addr = {part_q, 1'b1};
				hi_d = hash_data;
				state_d = ST_RD_CAP;
			end
			ST_RD_CAP: begin
				out_load = 1'b1;
				if (part_q == PartLast) begin
					ctl.rehash = 1'b1;
					part_d = '0;
					state_d = ST_IDLE;
				end else begin
					part_d = part_q + 2'd1;
					state_d = ST_RD_HI;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			after_q <= ST_IDLE;
			pos_q <= '0;
			len_q <= '0;
			first_q <= 1'b0;
			tail_q <= 1'b0;
			part_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			after_q <= after_d;
			len_q <= len_d;
			first_q <= first_d;
			tail_q <= tail_d;
			part_q <= part_d;
			if (put_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hi_q <= hi_d;
		if (put_en) begin
			word_q <= put_word;
		end
		if (out_load) begin
			out_data_q <= {hi_q, hash_data};
			out_idx_q <= part_q;
			out_last_q <= (part_q == PartLast);
		end
	end

	assign digest.valid = out_valid_q;
	assign digest.digest_part = out_data_q;
	assign digest.part_index = out_idx_q;
	assign digest.last_part = out_last_q;

	shs_blk_mem u_blk_mem (
		.clk   (clk),
		.we    (put_en && pos_q[1:0] == 2'd3),
		.waddr (pos_q[PosW-1:2]),
		.wdata (put_word),
		.raddr (blk_raddr),
		.rdata (blk_rdata)
	);

	shs_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.done     (core_done),
		.blk_addr (blk_raddr),
		.blk_data (blk_rdata),
		.rd_addr  (hash_addr),
		.rd_data  (hash_data)
	);

endmodule
